// ===== design/sds_pkg.sv =====
package sds_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_REQUESTS_DEF = 32;
  localparam int TRACK_BITS_DEF   = 12;

  // Fixed field and register widths
  localparam int MOVE_W   = 18;
  localparam int START_W  = 12;
  localparam int TRACKS_W = 13;
  localparam int CFG_W    = 13;
  localparam int REG_IDX_W = 1;

  localparam logic [MOVE_W-1:0]   MOVE_MAX        = 18'h3FFFF;
  localparam logic [TRACKS_W-1:0] DISK_TRACKS_RST = 13'd200;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_START_HEAD  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_DISK_TRACKS = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS,
    ST_HEAD,
    ST_UP_RD,
    ST_UP_CHK,
    ST_UP_MOV,
    ST_END,
    ST_DN_RD,
    ST_DN_CHK,
    ST_DN_MOV
  } state_t;

  // Result of the shared compare and movement unit
  typedef struct packed {
    logic              lt;
    logic [MOVE_W-1:0] total;
  } alu_res_t;

endpackage

// ===== design/sds_store.sv =====
module sds_store #(
  parameter int DEPTH = sds_pkg::MAX_REQUESTS_DEF,
  parameter int AW    = 5,
  parameter int TB    = sds_pkg::TRACK_BITS_DEF
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [TB-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [TB-1:0] rdata
);

  logic [TB-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sds_alu.sv =====
module sds_alu #(
  parameter int TB = sds_pkg::TRACK_BITS_DEF
) (
  input  logic [TB-1:0]             a,
  input  logic [TB-1:0]             b,
  input  logic [sds_pkg::MOVE_W-1:0] total,
  output sds_pkg::alu_res_t         res
);

  localparam int SW = ((TB > sds_pkg::MOVE_W) ? TB : sds_pkg::MOVE_W) + 1;

  logic [TB-1:0] diff;
  logic [SW-1:0] sum;

  // Compare, absolute distance and saturating running total
  always_comb begin
    diff = (a > b) ? (a - b) : (b - a);
    sum  = SW'(total) + SW'(diff);
    res.lt = (a < b);
    if (sum > SW'(sds_pkg::MOVE_MAX)) begin
      res.total = sds_pkg::MOVE_MAX;
    end else begin
      res.total = sum[sds_pkg::MOVE_W-1:0];
    end
  end

endmodule

// ===== design/scan_disk_scheduler.sv =====
// Channel  Direction  Handshake              tdata / tuser / tlast
// in_      slave      in_tvalid, in_tready   tdata: track; tlast: last_request
// out_     master     out_tvalid, out_tready tdata: position, movement_total;
//                                            tlast: final_res
// cfg_     write      cfg_we                 cfg_addr: register, cfg_wdata: value
//
// Each request is inserted into the sorted store, one entry shifted per
// cycle through the request memory, which has one write and one read port.
// After the last request the seek sequence is produced by one shared
// compare and movement unit: the start head, the stored requests at or above
// it on the upward pass, the turning track that closes that pass, then the
// requests below the head on the way down; out_tready stalls hold it.
// Reset (rst_n low, synchronous) empties the batch and restores the registers.
// in_tready is high only in the idle state: between insertions and while no seek sequence is being produced.
module scan_disk_scheduler #(
  parameter int MAX_REQUESTS = sds_pkg::MAX_REQUESTS_DEF,
  parameter int TRACK_BITS   = sds_pkg::TRACK_BITS_DEF,
  localparam int IN_W  = ((TRACK_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((TRACK_BITS + sds_pkg::MOVE_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [IN_W-1:0]                in_tdata,   // [TRACK_BITS-1:0] track
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_W-1:0]               out_tdata,  // position, movement_total
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [sds_pkg::REG_IDX_W-1:0]  cfg_addr,
  input  logic [sds_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int TB = TRACK_BITS;
  localparam logic [31:0] TRACK_MASK = 32'((64'd1 << TB) - 64'd1);

  // Configuration registers
  logic [sds_pkg::START_W-1:0]  start_head_r;
  logic [sds_pkg::TRACKS_W-1:0] disk_tracks_r;

  // Sequencer state
  sds_pkg::state_t              state_r, state_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [CW-1:0]                j_r, j_nxt;
  logic [CW-1:0]                i_r, i_nxt;
  logic [TB-1:0]                v_r, v_nxt;
  logic                         last_r, last_nxt;
  logic                         low_r, low_nxt;
  logic [TB-1:0]                cur_r, cur_nxt;
  logic [sds_pkg::MOVE_W-1:0]   tot_r, tot_nxt;

  // Output register
  logic                         out_valid_r, out_valid_nxt;
  logic [TB-1:0]                out_pos_r;
  logic [sds_pkg::MOVE_W-1:0]   out_tot_r;
  logic                         out_fin_r;

  // Datapath signals
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr, mem_raddr;
  logic [TB-1:0]                mem_wdata, rd;
  logic [TB-1:0]                alu_a, alu_b;
  sds_pkg::alu_res_t            alu_res;
  logic                         push, push_fin, slot_free;
  logic [TB-1:0]                push_pos;
  logic [sds_pkg::MOVE_W-1:0]   push_tot;
  logic [TB-1:0]                track, head, end_trk;
  logic [31:0]                  head_ext, end_ext;
  logic [sds_pkg::TRACKS_W-1:0] end_raw;
  logic [CW-1:0]                cnt_m1, j_m2;

  assign track     = in_tdata[TB-1:0];
  assign in_tready = (state_r == sds_pkg::ST_IDLE);
  assign slot_free = !out_valid_r || out_tready;
  assign cnt_m1    = cnt_r - CW'(1);
  assign j_m2      = j_r - CW'(2);

  // Head cut and turning track clipped to the track width
  always_comb begin
    head_ext = 32'(start_head_r);
    head     = head_ext[TB-1:0];
    end_raw  = (disk_tracks_r == '0) ? '0 : (disk_tracks_r - 1'b1);
    end_ext  = 32'(end_raw);
    end_trk  = (end_ext > TRACK_MASK) ? TRACK_MASK[TB-1:0] : end_ext[TB-1:0];
  end

  sds_store #(
    .DEPTH (MAX_REQUESTS),
    .AW    (AW),
    .TB    (TB)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd)
  );

  sds_alu #(
    .TB (TB)
  ) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .total (tot_r),
    .res   (alu_res)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_head_r  <= '0;
      disk_tracks_r <= sds_pkg::DISK_TRACKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sds_pkg::REG_START_HEAD:  start_head_r  <= cfg_wdata[sds_pkg::START_W-1:0];
        sds_pkg::REG_DISK_TRACKS: disk_tracks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sds_pkg::ST_IDLE;
      cnt_r   <= '0;
      low_r   <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      low_r   <= low_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r   <= j_nxt;
    i_r   <= i_nxt;
    v_r   <= v_nxt;
    cur_r <= cur_nxt;
    tot_r <= tot_nxt;
  end

  // Next state, memory and unit control
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    j_nxt     = j_r;
    i_nxt     = i_r;
    v_nxt     = v_r;
    last_nxt  = last_r;
    low_nxt   = low_r;
    cur_nxt   = cur_r;
    tot_nxt   = tot_r;
    mem_we    = 1'b0;
    mem_waddr = j_r[AW-1:0];
    mem_wdata = v_r;
    mem_raddr = i_r[AW-1:0];
    alu_a     = rd;
    alu_b     = head;
    push      = 1'b0;
    push_pos  = rd;
    push_tot  = alu_res.total;
    push_fin  = 1'b0;

    unique case (state_r)
      sds_pkg::ST_IDLE: begin
        // Fetch the current top entry ahead of an insertion
        mem_raddr = cnt_m1[AW-1:0];
        if (in_tvalid) begin
          if (cnt_r < CW'(MAX_REQUESTS)) begin
            v_nxt     = track;
            j_nxt     = cnt_r;
            last_nxt  = in_tlast;
            state_nxt = sds_pkg::ST_INS;
          end else if (in_tlast) begin
            state_nxt = sds_pkg::ST_HEAD;
          end
        end
      end

      sds_pkg::ST_INS: begin
        // Shift larger entries up one place, then drop the new one in
        alu_a  = v_r;
        alu_b  = rd;
        mem_we = 1'b1;
        if (j_r != '0 && alu_res.lt) begin
          mem_wdata = rd;
          j_nxt     = j_r - CW'(1);
          mem_raddr = j_m2[AW-1:0];
        end else begin
          mem_wdata = v_r;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = last_r ? sds_pkg::ST_HEAD : sds_pkg::ST_IDLE;
        end
      end

      sds_pkg::ST_HEAD: begin
        push_pos = head;
        push_tot = '0;
        if (slot_free) begin
          push      = 1'b1;
          cur_nxt   = head;
          tot_nxt   = '0;
          i_nxt     = '0;
          state_nxt = sds_pkg::ST_UP_RD;
        end
      end

      sds_pkg::ST_UP_RD: begin
        state_nxt = (i_r == cnt_r) ? sds_pkg::ST_END : sds_pkg::ST_UP_CHK;
      end

      sds_pkg::ST_UP_CHK: begin
        // Skip requests below the head; note whether the lowest one is
        if (i_r == '0) begin
          low_nxt = alu_res.lt;
        end
        if (alu_res.lt) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = sds_pkg::ST_UP_RD;
        end else begin
          state_nxt = sds_pkg::ST_UP_MOV;
        end
      end

      sds_pkg::ST_UP_MOV: begin
        alu_b = cur_r;
        if (slot_free) begin
          push      = 1'b1;
          cur_nxt   = rd;
          tot_nxt   = alu_res.total;
          i_nxt     = i_r + CW'(1);
          state_nxt = sds_pkg::ST_UP_RD;
        end
      end

      sds_pkg::ST_END: begin
        alu_a    = end_trk;
        alu_b    = cur_r;
        push_pos = end_trk;
        push_fin = !low_r;
        if (slot_free) begin
          push    = 1'b1;
          cur_nxt = end_trk;
          tot_nxt = alu_res.total;
          if (low_r) begin
            i_nxt     = cnt_m1;
            state_nxt = sds_pkg::ST_DN_RD;
          end else begin
            cnt_nxt   = '0;
            state_nxt = sds_pkg::ST_IDLE;
          end
        end
      end

      sds_pkg::ST_DN_RD: begin
        state_nxt = sds_pkg::ST_DN_CHK;
      end

      sds_pkg::ST_DN_CHK: begin
        if (alu_res.lt) begin
          state_nxt = sds_pkg::ST_DN_MOV;
        end else if (i_r == '0) begin
          cnt_nxt   = '0;
          state_nxt = sds_pkg::ST_IDLE;
        end else begin
          i_nxt     = i_r - CW'(1);
          state_nxt = sds_pkg::ST_DN_RD;
        end
      end

      sds_pkg::ST_DN_MOV: begin
        // The lowest request closes the sequence
        alu_b    = cur_r;
        push_fin = (i_r == '0);
        if (slot_free) begin
          push    = 1'b1;
          cur_nxt = rd;
          tot_nxt = alu_res.total;
          if (i_r == '0) begin
            cnt_nxt   = '0;
            state_nxt = sds_pkg::ST_IDLE;
          end else begin
            i_nxt     = i_r - CW'(1);
            state_nxt = sds_pkg::ST_DN_RD;
          end
        end
      end

      default: state_nxt = sds_pkg::ST_IDLE;
    endcase
  end

  // Hold a result until its transfer, load the next one behind it
  always_comb begin
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_pos_r <= push_pos;
      out_tot_r <= push_tot;
      out_fin_r <= push_fin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_tot_r, out_pos_r});
  assign out_tlast  = out_fin_r;

endmodule

// ===== design/sds_checker.sv =====
module sds_checker #(
  parameter int OUT_W = 32
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tlast
);

  // Leave the idle state only on an input transfer
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid && in_tready))
    else $error("in_tready dropped without an input transfer");

  // A pending non-final result means a batch is still being emitted
  a_busy_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input accepted while a batch is still emitted");

  // A new result is only produced while the input side is busy
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result produced while idle");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind scan_disk_scheduler sds_checker #(
  .OUT_W (OUT_W)
) u_sds_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
